/* hw/rtl/pgtd_pkg.sv */
// ----------------------------------------------------------------------------
// pgtd_pkg
// Shared widths, defaults, register codes and the preset prime entries for
// the trial-division prime generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pgtd_pkg;

   // index / count fields (prime_limit, prime_index)
   localparam int IDX_W           = 13;
   // prime_value field on the response port
   localparam int VALUE_OUT_W     = 16;

   // default sizes for the top level
   localparam int DEF_MAX_PRIMES  = 4096;
   localparam int DEF_VALUE_WIDTH = 16;

   // limit register
   localparam logic [IDX_W-1:0] LIMIT_RESET = IDX_W'(4096);
   localparam logic [IDX_W-1:0] LIMIT_MIN   = IDX_W'(5);

   // number of entries preset in the table (2, 3, 5)
   localparam int PRESET_COUNT    = 3;
   // first odd candidate after the preset entries
   localparam int FIRST_CANDIDATE = 7;

   // CSR map: byte address width and word index of each register
   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-3:0] REG_PRIME_LIMIT = '0;

   // preset table entries, for table index 0..2
   function automatic logic [7:0] preset_prime(input logic [1:0] k);
      logic [7:0] v;
      unique case (k)
         2'd0:    v = 8'd2;
         2'd1:    v = 8'd3;
         2'd2:    v = 8'd5;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/prime_generator_trial_division.sv */
// ----------------------------------------------------------------------------
// prime_generator_trial_division
// Returns the next prime of the sequence for each request. Found primes are
// kept in a single-port table memory; candidates are tested by trial division
// against the stored odd primes with a bit-serial remainder unit.
//
//   channel   direction  handshake           payload
//   req       in         req_valid/stall     req_restart
//   rsp       out        rsp_valid/stall     rsp_prime_index, rsp_prime_value,
//                                            rsp_last, rsp_exhausted
//   csr       in/out     APB (pready = 1)    prime_limit at byte address 0
//
// One request at a time. A prime already in the table passes S_CHECK,
// S_FETCH and S_FWAIT, an exhausted response only S_CHECK, and both then
// S_OUT on the way to the response register. A new prime is sought candidate
// by candidate: each passes S_CHECK, then for every stored prime divided a
// table read, a read wait and one remainder bit per cycle; the candidate
// found prime stops in S_RD or S_PWAIT and goes through S_OUT.
// Synchronous active-high reset; the table needs no clearing pass, the
// preset entries 2, 3, 5 are supplied by logic. A new request is taken while
// a finished response still waits under rsp_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_generator_trial_division
   import pgtd_pkg::*;
#(
   parameter int MAX_PRIMES  = DEF_MAX_PRIMES,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_restart,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [IDX_W-1:0]            rsp_prime_index,
   output logic [VALUE_OUT_W-1:0]      rsp_prime_value,
   output logic                        rsp_last,
   output logic                        rsp_exhausted,

   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_AW-1:0]      csr_paddr,
   input  wire logic [31:0]            csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int VW    = VALUE_WIDTH;
   localparam int AW    = $clog2(MAX_PRIMES);
   localparam int CNT_W = $clog2(VW);
   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_PRIMES);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_PWAIT = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_FETCH = 3'd5;
   localparam logic [2:0] S_FWAIT = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  limit_ff;
   logic [IDX_W-1:0]  found_ff, found_in;
   logic [IDX_W-1:0]  emitted_ff, emitted_in;
   logic [VW:0]       cand_ff, cand_in;
   logic [IDX_W-1:0]  k_ff, k_in;

   // remainder unit
   logic [VW-1:0]     p_ff, p_in;
   logic [VW:0]       rem_ff, rem_in;
   logic [VW-1:0]     dvd_ff, dvd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [VW:0]       rem_shift, rem_step;

   // table memory
   logic [VW-1:0]     mem [MAX_PRIMES];
   logic [VW-1:0]     mem_rd_ff;
   logic              rd_fix_ff;
   logic [VW-1:0]     rd_fix_val_ff;
   logic              mem_re, mem_we;
   logic [AW-1:0]     mem_ra;
   logic [VW-1:0]     rd_val;

   // pending result
   logic              res_load;
   logic              res_exh;
   logic [VW-1:0]     res_val;
   logic [IDX_W-1:0]  res_index_ff;
   logic [VW-1:0]     res_value_ff;
   logic              res_last_ff, res_exh_ff;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_load;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic [VW-1:0]     rsp_value_ff;
   logic              rsp_last_ff, rsp_exh_ff;

   logic [IDX_W-1:0]  lim_eff;
   logic [IDX_W-1:0]  next_index;
   logic [VW-1:0]     cand_val;
   logic              csr_wr;

   // limit clamped to MIN .. MAX_PRIMES
   always_comb begin
      priority if (limit_ff < LIMIT_MIN) begin
         lim_eff = LIMIT_MIN;
      end else if (limit_ff > MAX_IDX) begin
         lim_eff = MAX_IDX;
      end else begin
         lim_eff = limit_ff;
      end
   end

   assign cand_val   = cand_ff[VW-1:0];
   assign next_index = emitted_ff + IDX_W'(1);
   assign rd_val     = rd_fix_ff ? rd_fix_val_ff : mem_rd_ff;

   // one restoring remainder step
   assign rem_shift = {rem_ff[VW-1:0], dvd_ff[VW-1]};
   assign rem_step  = (rem_shift >= {1'b0, p_ff}) ? (rem_shift - {1'b0, p_ff}) : rem_shift;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      found_in   = found_ff;
      emitted_in = emitted_ff;
      cand_in    = cand_ff;
      k_in       = k_ff;
      p_in       = p_ff;
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      cnt_in     = cnt_ff;
      mem_re     = 1'b0;
      mem_we     = 1'b0;
      mem_ra     = k_ff[AW-1:0];
      res_load   = 1'b0;
      res_exh    = 1'b0;
      res_val    = rd_val;
      rsp_load   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  found_in   = IDX_W'(PRESET_COUNT);
                  emitted_in = '0;
                  cand_in    = (VW+1)'(FIRST_CANDIDATE);
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (emitted_ff >= lim_eff) begin
               res_load = 1'b1;
               res_exh  = 1'b1;
               state_in = S_OUT;
            end else if (emitted_ff == found_ff) begin
               if (found_ff == MAX_IDX || cand_ff[VW]) begin
                  res_load = 1'b1;
                  res_exh  = 1'b1;
                  state_in = S_OUT;
               end else begin
                  k_in     = IDX_W'(1);
                  state_in = S_RD;
               end
            end else begin
               state_in = S_FETCH;
            end
         end
         S_RD: begin
            if (k_ff >= found_ff) begin
               // no stored prime divides: append and return it
               mem_we     = 1'b1;
               found_in   = found_ff + IDX_W'(1);
               cand_in    = cand_ff + (VW+1)'(2);
               res_load   = 1'b1;
               res_val    = cand_val;
               emitted_in = next_index;
               state_in   = S_OUT;
            end else begin
               mem_re   = 1'b1;
               state_in = S_PWAIT;
            end
         end
         S_PWAIT: begin
            if (rd_val > (cand_val >> 1)) begin
               mem_we     = 1'b1;
               found_in   = found_ff + IDX_W'(1);
               cand_in    = cand_ff + (VW+1)'(2);
               res_load   = 1'b1;
               res_val    = cand_val;
               emitted_in = next_index;
               state_in   = S_OUT;
            end else begin
               p_in     = rd_val;
               rem_in   = '0;
               dvd_in   = cand_val;
               cnt_in   = CNT_W'(VW-1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = rem_step;
            dvd_in = {dvd_ff[VW-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               if (rem_step == '0) begin
                  // composite: next odd candidate
                  cand_in  = cand_ff + (VW+1)'(2);
                  state_in = S_CHECK;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = S_RD;
               end
            end
         end
         S_FETCH: begin
            mem_re   = 1'b1;
            mem_ra   = emitted_ff[AW-1:0];
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            res_load   = 1'b1;
            emitted_in = next_index;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= LIMIT_RESET;
         found_ff     <= IDX_W'(PRESET_COUNT);
         emitted_ff   <= '0;
         cand_ff      <= (VW+1)'(FIRST_CANDIDATE);
         k_ff         <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         emitted_ff   <= emitted_in;
         cand_ff      <= cand_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            limit_ff <= csr_pwdata[IDX_W-1:0];
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      if (res_load) begin
         res_exh_ff   <= res_exh;
         res_index_ff <= res_exh ? '0 : next_index;
         res_value_ff <= res_exh ? '0 : res_val;
         res_last_ff  <= !res_exh && (next_index == lim_eff);
      end
      if (rsp_load) begin
         rsp_index_ff <= res_index_ff;
         rsp_value_ff <= res_value_ff;
         rsp_last_ff  <= res_last_ff;
         rsp_exh_ff   <= res_exh_ff;
      end
   end

   // prime table; the preset entries come from logic, never from the array
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[found_ff[AW-1:0]] <= cand_val;
      end
      if (mem_re) begin
         mem_rd_ff     <= mem[mem_ra];
         rd_fix_ff     <= ({{(32-AW){1'b0}}, mem_ra} < 32'(PRESET_COUNT));
         rd_fix_val_ff <= VW'(preset_prime(mem_ra[1:0]));
      end
   end

   // CSR port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                    && (csr_paddr[CSR_AW-1:2] == REG_PRIME_LIMIT);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == REG_PRIME_LIMIT) ? 32'(limit_ff) : 32'd0;

   // outputs
   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_index = rsp_index_ff;
   assign rsp_prime_value = VALUE_OUT_W'(rsp_value_ff);
   assign rsp_last        = rsp_last_ff;
   assign rsp_exhausted   = rsp_exh_ff;

endmodule

`default_nettype wire

/* hw/rtl/pgtd_checker.sv */
// ----------------------------------------------------------------------------
// pgtd_checker
// Port-level checks for the prime generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pgtd_checker
   import pgtd_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [IDX_W-1:0]       rsp_prime_index,
   input wire logic [VALUE_OUT_W-1:0] rsp_prime_value,
   input wire logic                   rsp_last,
   input wire logic                   rsp_exhausted,
   input wire logic                   csr_pready
);

   // exhausted responses carry no prime
   a_exh_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exhausted |->
         rsp_prime_index == '0 && rsp_prime_value == '0 && !rsp_last)
      else $error("exhausted response with nonzero payload");

   // a prime response has a nonzero index
   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_exhausted |-> rsp_prime_index != '0)
      else $error("prime response with zero index");

   // a returned prime is two or odd
   a_odd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_exhausted |->
         rsp_prime_value[0] || rsp_prime_value == VALUE_OUT_W'(2))
      else $error("even value other than two returned");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_prime_index)
         && $stable(rsp_prime_value) && $stable(rsp_last) && $stable(rsp_exhausted))
      else $error("stalled response changed");

   // register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule

bind prime_generator_trial_division pgtd_checker u_pgtd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_prime_index (rsp_prime_index),
   .rsp_prime_value (rsp_prime_value),
   .rsp_last        (rsp_last),
   .rsp_exhausted   (rsp_exhausted),
   .csr_pready      (csr_pready)
);

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for prime_generator_trial_division. A table of directed requests
// and limit writes covers the first primes, the last-prime mark, exhaustion,
// limit clamping and masking, and restart. Random phases with random limits
// follow. Every response is checked against a trial-division predictor kept
// in the testbench. Both channels idle at random except in the final phases.
// ----------------------------------------------------------------------------
module tb_top;
   import pgtd_pkg::*;

   // one response of the block
   typedef struct packed {
      logic [IDX_W-1:0]       index;
      logic [VALUE_OUT_W-1:0] value;
      logic                   last;
      logic                   exhausted;
   } prime_rsp_type;

   typedef enum logic {ROW_REQUEST, ROW_LIMIT} row_kind_type;

   // directed step: a request (with an optional known answer) or a limit write
   typedef struct packed {
      row_kind_type  kind;
      logic          restart;
      logic [31:0]   limit_word;
      logic          known;
      prime_rsp_type want;
   } plan_row_type;

   localparam prime_rsp_type NO_RSP = '0;
   localparam prime_rsp_type GONE   = '{index: '0, value: '0, last: 1'b0, exhausted: 1'b1};
   localparam logic [CSR_AW-1:0] LIMIT_ADDR = {REG_PRIME_LIMIT, 2'b00};
   localparam int VALUE_MAX = (1 << DEF_VALUE_WIDTH) - 1;
   localparam int PLAN_LEN  = 27;

   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // first primes after reset, limit at its reset value
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b1, '{13'd1, 16'd2, 1'b0, 1'b0}},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b1, '{13'd2, 16'd3, 1'b0, 1'b0}},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b1, '{13'd3, 16'd5, 1'b0, 1'b0}},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b1, '{13'd4, 16'd7, 1'b0, 1'b0}},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b0, NO_RSP},
      // limit 6: sixth prime is last, then exhausted
      '{ROW_LIMIT,   1'b0, 32'd6, 1'b0, NO_RSP},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b1, '{13'd6, 16'd13, 1'b1, 1'b0}},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b1, GONE},
      // limit 0 clamps to the minimum, already passed
      '{ROW_LIMIT,   1'b0, 32'd0, 1'b0, NO_RSP},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b1, GONE},
      // upper bits dropped: limit 9, sequence resumes
      '{ROW_LIMIT,   1'b0, 32'h0000_2009, 1'b0, NO_RSP},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b0, NO_RSP},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b0, NO_RSP},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b0, NO_RSP},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b1, GONE},
      // restart from exhaustion
      '{ROW_REQUEST, 1'b1, 32'd0, 1'b1, '{13'd1, 16'd2, 1'b0, 1'b0}},
      // all ones clamps to the table size
      '{ROW_LIMIT,   1'b0, 32'd8191, 1'b0, NO_RSP},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b0, NO_RSP},
      // high bits set, low bits give the minimum limit
      '{ROW_LIMIT,   1'b0, 32'hFFFF_E005, 1'b0, NO_RSP},
      '{ROW_REQUEST, 1'b1, 32'd0, 1'b1, '{13'd1, 16'd2, 1'b0, 1'b0}},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b0, NO_RSP},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b0, NO_RSP},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b0, NO_RSP},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b1, '{13'd5, 16'd11, 1'b1, 1'b0}},
      '{ROW_REQUEST, 1'b0, 32'd0, 1'b1, GONE},
      '{ROW_LIMIT,   1'b0, 32'd4096, 1'b0, NO_RSP},
      '{ROW_REQUEST, 1'b1, 32'd0, 1'b1, '{13'd1, 16'd2, 1'b0, 1'b0}}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_restart = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [IDX_W-1:0]       rsp_prime_index;
   logic [VALUE_OUT_W-1:0] rsp_prime_value;
   logic                   rsp_last;
   logic                   rsp_exhausted;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr = LIMIT_ADDR;
   logic [31:0]            csr_pwdata = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   // predictor state
   logic [VALUE_OUT_W-1:0] prime_store [DEF_MAX_PRIMES];
   logic [IDX_W-1:0]       found_count;
   logic [IDX_W-1:0]       emitted_count;
   logic [16:0]            next_candidate;
   logic [IDX_W-1:0]       limit_shadow;

   prime_rsp_type pending_primes [$];
   int            mismatch_count = 0;
   int            stall_left = 0;
   bit            idle_en = 1'b1;

   always #1 clock = ~clock;

   prime_generator_trial_division u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_index (rsp_prime_index),
      .rsp_prime_value (rsp_prime_value),
      .rsp_last        (rsp_last),
      .rsp_exhausted   (rsp_exhausted),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // back to the preset table 2, 3, 5 and the first odd candidate
   function automatic void clear_sequence();
      prime_store[0] = 16'd2;
      prime_store[1] = 16'd3;
      prime_store[2] = 16'd5;
      found_count    = IDX_W'(PRESET_COUNT);
      emitted_count  = '0;
      next_candidate = 17'(FIRST_CANDIDATE);
   endfunction

   // answer one request, searching for a new prime when the table runs out
   function automatic prime_rsp_type next_prime(input logic restart);
      prime_rsp_type    r;
      logic [IDX_W-1:0] lim;
      logic [16:0]      c;
      bit               ok;
      bit               stop;
      bit               composite;
      int               k;
      r = '0;
      if (restart)
         clear_sequence();
      lim = limit_shadow;
      if (lim < LIMIT_MIN)
         lim = LIMIT_MIN;
      if (lim > IDX_W'(DEF_MAX_PRIMES))
         lim = IDX_W'(DEF_MAX_PRIMES);
      ok = (emitted_count < lim);
      if (ok && emitted_count >= found_count) begin
         ok = 1'b0;
         while (!ok && found_count < DEF_MAX_PRIMES && next_candidate <= VALUE_MAX) begin
            c = next_candidate;
            composite = 1'b0;
            stop = 1'b0;
            // divide by stored odd primes up to half the candidate
            for (k = 1; k < found_count && !stop; k++) begin
               if (prime_store[k] > c / 2)
                  stop = 1'b1;
               else if (prime_store[k] != 0 && c % prime_store[k] == 0) begin
                  composite = 1'b1;
                  stop = 1'b1;
               end
            end
            next_candidate = c + 17'd2;
            if (!composite) begin
               prime_store[found_count] = c[VALUE_OUT_W-1:0];
               found_count = found_count + IDX_W'(1);
               ok = 1'b1;
            end
         end
      end
      if (ok) begin
         r.index = emitted_count + IDX_W'(1);
         r.value = prime_store[emitted_count];
         r.last  = (r.index == lim);
         emitted_count = emitted_count + IDX_W'(1);
      end else begin
         r.exhausted = 1'b1;
      end
      return r;
   endfunction

   // one request; known answers replace the predicted one
   task automatic send_request(input logic restart, input bit known,
                               input prime_rsp_type fixed);
      prime_rsp_type want;
      int            gap;
      if (idle_en && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      want = next_prime(restart);
      pending_primes.push_back(known ? fixed : want);
   endtask

   // hold requests until every response is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_primes.size() != 0)
         @(posedge clock);
   endtask

   // write prime_limit, then read it back
   task automatic write_limit(input logic [31:0] word);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      limit_shadow = word[IDX_W-1:0];
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== 32'(limit_shadow)) begin
         $error("prime_limit expected %0d actual %0d", limit_shadow, csr_prdata);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // response stalls in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each accepted response with the oldest expectation
   always @(posedge clock) begin : check_responses
      prime_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_primes.size() == 0) begin
            $error("response with no request pending: index %0d value %0d",
                   rsp_prime_index, rsp_prime_value);
            mismatch_count++;
         end else begin
            want = pending_primes.pop_front();
            if (rsp_prime_index !== want.index) begin
               $error("prime_index expected %0d actual %0d", want.index, rsp_prime_index);
               mismatch_count++;
            end
            if (rsp_prime_value !== want.value) begin
               $error("prime_value expected %0d actual %0d", want.value, rsp_prime_value);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last expected %0b actual %0b", want.last, rsp_last);
               mismatch_count++;
            end
            if (rsp_exhausted !== want.exhausted) begin
               $error("exhausted expected %0b actual %0b", want.exhausted, rsp_exhausted);
               mismatch_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      int          i;
      int          phase;
      int          n;
      logic [31:0] word;
      clear_sequence();
      limit_shadow = LIMIT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (i = 0; i < PLAN_LEN; i++) begin
         if (PLAN[i].kind == ROW_LIMIT) begin
            wait_for_drain();
            write_limit(PLAN[i].limit_word);
         end else begin
            send_request(PLAN[i].restart, PLAN[i].known, PLAN[i].want);
         end
      end

      // random phases; the last two run without idling
      for (phase = 0; phase < 7; phase++) begin
         idle_en = (phase < 5);
         wait_for_drain();
         case ($urandom_range(0, 7))
            0:       word = $urandom_range(0, 4);
            1:       word = $urandom_range(4096, 8191);
            2:       word = $urandom();
            3:       word = $urandom_range(5, 40);
            default: word = 32'(emitted_count) + $urandom_range(1, 25);
         endcase
         write_limit(word);
         // mostly continuing requests, a rare restart
         for (n = 0; n < 17; n++)
            send_request($urandom_range(0, 29) == 0, 1'b0, NO_RSP);
      end

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_primes.size() == 0)
         $display("** prime_generator_trial_division: PASSED **");
      else
         $display("** prime_generator_trial_division: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("** prime_generator_trial_division: FAILED **");
      $finish;
   end

endmodule
